>>> design/stc_pkg.sv
// Shared types, constants and row functions for the stabilizer tableau block
`timescale 1ns / 1ps

package stc_pkg;

  localparam int MAX_QUBITS = 16;
  localparam int ROW_COUNT  = 2 * MAX_QUBITS;
  localparam int ROW_W      = $clog2(ROW_COUNT);
  localparam int QIDX_W     = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
  localparam int QCNT_W     = $clog2(MAX_QUBITS + 1);
  localparam int GATE_W     = 3;
  localparam int QB_W       = 5;
  localparam int NQ_W       = 5;
  localparam int SIGNS_W    = 32;

  // Gate codes
  localparam logic [GATE_W-1:0] GATE_H    = 3'd0;
  localparam logic [GATE_W-1:0] GATE_S    = 3'd1;
  localparam logic [GATE_W-1:0] GATE_X    = 3'd2;
  localparam logic [GATE_W-1:0] GATE_Z    = 3'd3;
  localparam logic [GATE_W-1:0] GATE_Y    = 3'd4;
  localparam logic [GATE_W-1:0] GATE_CNOT = 3'd5;

  typedef struct packed {
    logic [GATE_W-1:0] gate;
    logic [QB_W-1:0]   qubit_a;
    logic [QB_W-1:0]   qubit_b;
  } in_t;

  typedef struct packed {
    logic               error;
    logic               stabilizers_commute;
    logic [SIGNS_W-1:0] row_signs;
  } out_t;

  typedef struct packed {
    logic [MAX_QUBITS-1:0] x;
    logic [MAX_QUBITS-1:0] z;
  } row_t;

  typedef struct packed {
    row_t row;
    logic flip;
  } row_upd_t;

  // Tableau memory access: one write port, two read ports
  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] waddr;
    row_t             wdata;
    logic [ROW_W-1:0] raddr_a;
    logic [ROW_W-1:0] raddr_b;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_APPLY,
    ST_PREP,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Zero or anything above the maximum selects the maximum
  function automatic logic [QCNT_W-1:0] effective_n(input logic [NQ_W-1:0] v);
    logic [QCNT_W-1:0] res;
    if (v == '0 || 32'(v) > MAX_QUBITS) begin
      res = QCNT_W'(MAX_QUBITS);
    end else begin
      res = QCNT_W'(v);
    end
    return res;
  endfunction

  // Starting content of one row: destabilisers X_i, stabilisers Z_i
  function automatic row_t init_row(input logic [ROW_W-1:0] r,
                                    input logic [QCNT_W-1:0] n);
    row_t          res;
    logic [ROW_W:0] rr;
    logic [ROW_W:0] nn;
    logic [ROW_W:0] twon;
    logic [ROW_W:0] off;
    rr   = {1'b0, r};
    nn   = (ROW_W + 1)'(n);
    twon = nn << 1;
    off  = rr - nn;
    res  = '0;
    if (rr < nn) begin
      res.x[r[QIDX_W-1:0]] = 1'b1;
    end
    if (rr >= nn && rr < twon) begin
      res.z[off[QIDX_W-1:0]] = 1'b1;
    end
    return res;
  endfunction

  // Conjugate one row by a gate and give its sign flip
  function automatic row_upd_t apply_gate(input row_t row,
                                          input logic [GATE_W-1:0] g,
                                          input logic [QIDX_W-1:0] a,
                                          input logic [QIDX_W-1:0] b);
    row_upd_t res;
    logic     xa;
    logic     za;
    logic     xb;
    logic     zb;
    xa       = row.x[a];
    za       = row.z[a];
    xb       = row.x[b];
    zb       = row.z[b];
    res.row  = row;
    res.flip = 1'b0;
    case (g)
      GATE_H: begin
        res.flip     = xa & za;
        res.row.x[a] = za;
        res.row.z[a] = xa;
      end
      GATE_S: begin
        res.flip     = xa & za;
        res.row.z[a] = za ^ xa;
      end
      GATE_X: res.flip = za;
      GATE_Z: res.flip = xa;
      GATE_Y: res.flip = xa ^ za;
      GATE_CNOT: begin
        res.flip     = xa & zb & ~(xb ^ za);
        res.row.x[b] = xb ^ xa;
        res.row.z[a] = za ^ zb;
      end
      default: res.flip = 1'b0;
    endcase
    return res;
  endfunction

endpackage

>>> design/stc_tab_mem.sv
// Tableau row memory: one write port, two registered read ports
`timescale 1ns / 1ps

module stc_tab_mem
  import stc_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output row_t     rd_a,
  output row_t     rd_b
);

  row_t mem [ROW_COUNT];

  // Write the addressed row
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read both ports into registered outputs
  always_ff @(posedge clk) begin
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

>>> design/stc_seq.sv
// Sequencer: tableau init sweep, gate row sweep and commutation pair sweep
`timescale 1ns / 1ps

module stc_seq
  import stc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [NQ_W-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_t             in_data,
  output logic            res_valid,
  input  logic            res_take,
  output out_t            result,
  output mem_req_t        req,
  input  row_t            rd_a,
  input  row_t            rd_b
);

  state_t               state, state_next;
  logic [QCNT_W-1:0]    nq, nq_next;
  logic [ROW_W-1:0]     cnt, cnt_next;
  logic [ROW_W-1:0]     cnt_b, cnt_b_next;
  logic [ROW_W-1:0]     prow, prow_next;
  logic                 issued, issued_next;
  logic                 pipe_vld, pipe_vld_next;
  logic [ROW_COUNT-1:0] sign, sign_next;
  logic                 acc, acc_next;
  logic                 err, err_next;
  logic [GATE_W-1:0]    gate, gate_next;
  logic [QIDX_W-1:0]    qa, qa_next;
  logic [QIDX_W-1:0]    qb, qb_next;

  logic [QCNT_W:0]      twon;
  logic [ROW_W-1:0]     last_row;
  logic                 bad_in;
  row_upd_t             upd;
  logic                 anti;

  assign twon     = {nq, 1'b0};
  assign last_row = ROW_W'(twon - 1'b1);

  // Reject out-of-range qubits and a CNOT onto itself
  assign bad_in = (in_data.qubit_a >= QB_W'(nq)) ||
                  (in_data.gate == GATE_CNOT &&
                   (in_data.qubit_b >= QB_W'(nq) || in_data.qubit_a == in_data.qubit_b));

  assign upd  = apply_gate(rd_a, gate, qa, qb);
  assign anti = ^((rd_a.x & rd_b.z) ^ (rd_b.x & rd_a.z));

  assign result.error               = err;
  assign result.stabilizers_commute = acc;
  assign result.row_signs           = SIGNS_W'(sign);

  // Next state and memory requests
  always_comb begin
    state_next    = state;
    nq_next       = nq;
    cnt_next      = cnt;
    cnt_b_next    = cnt_b;
    prow_next     = prow;
    issued_next   = issued;
    pipe_vld_next = pipe_vld;
    sign_next     = sign;
    acc_next      = acc;
    err_next      = err;
    gate_next     = gate;
    qa_next       = qa;
    qb_next       = qb;
    req           = '0;
    in_ready      = 1'b0;
    res_valid     = 1'b0;

    unique case (state)
      ST_INIT: begin
        req.we    = 1'b1;
        req.waddr = cnt;
        req.wdata = init_row(cnt, nq);
        if (cnt == ROW_W'(ROW_COUNT - 1)) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          gate_next     = in_data.gate;
          qa_next       = in_data.qubit_a[QIDX_W-1:0];
          qb_next       = in_data.qubit_b[QIDX_W-1:0];
          err_next      = bad_in;
          cnt_next      = '0;
          issued_next   = 1'b0;
          pipe_vld_next = 1'b0;
          if (!bad_in && in_data.gate <= GATE_CNOT) begin
            state_next = ST_APPLY;
          end else begin
            state_next = ST_PREP;
          end
        end
      end

      ST_APPLY: begin
        // issue reads row by row
        if (!issued) begin
          req.raddr_a   = cnt;
          pipe_vld_next = 1'b1;
          prow_next     = cnt;
          if (cnt == last_row) begin
            issued_next = 1'b1;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end else begin
          pipe_vld_next = 1'b0;
        end
        // modify and write back the row read last cycle
        if (pipe_vld) begin
          req.we          = 1'b1;
          req.waddr       = prow;
          req.wdata       = upd.row;
          sign_next[prow] = sign[prow] ^ upd.flip;
          if (prow == last_row) begin
            state_next = ST_PREP;
          end
        end
      end

      ST_PREP: begin
        cnt_next      = ROW_W'(nq);
        cnt_b_next    = ROW_W'(nq + 1'b1);
        acc_next      = 1'b1;
        issued_next   = (nq == QCNT_W'(1));
        pipe_vld_next = 1'b0;
        state_next    = ST_CHECK;
      end

      ST_CHECK: begin
        // walk stabiliser pairs i < j
        if (!issued) begin
          req.raddr_a   = cnt;
          req.raddr_b   = cnt_b;
          pipe_vld_next = 1'b1;
          if (cnt_b == last_row) begin
            if (ROW_W'(cnt + 1'b1) == last_row) begin
              issued_next = 1'b1;
            end else begin
              cnt_next   = cnt + 1'b1;
              cnt_b_next = ROW_W'(cnt + 2'd2);
            end
          end else begin
            cnt_b_next = cnt_b + 1'b1;
          end
        end else begin
          pipe_vld_next = 1'b0;
        end
        // drop the flag on any anticommuting pair
        if (pipe_vld && anti) begin
          acc_next = 1'b0;
        end
        if (issued && !pipe_vld) begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_INIT;
    endcase

    // A register write restarts the tableau
    if (cfg_we) begin
      nq_next       = effective_n(cfg_data);
      state_next    = ST_INIT;
      cnt_next      = '0;
      sign_next     = '0;
      issued_next   = 1'b0;
      pipe_vld_next = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      nq       <= effective_n(NQ_W'(MAX_QUBITS));
      cnt      <= '0;
      sign     <= '0;
      issued   <= 1'b0;
      pipe_vld <= 1'b0;
    end else begin
      state    <= state_next;
      nq       <= nq_next;
      cnt      <= cnt_next;
      sign     <= sign_next;
      issued   <= issued_next;
      pipe_vld <= pipe_vld_next;
    end
  end

  // Working registers of the current transaction
  always_ff @(posedge clk) begin
    cnt_b <= cnt_b_next;
    prow  <= prow_next;
    acc   <= acc_next;
    err   <= err_next;
    gate  <= gate_next;
    qa    <= qa_next;
    qb    <= qb_next;
  end

endmodule

>>> design/stabilizer_tableau_clifford_top.sv
// Top level of the stabilizer tableau block with its output register
//
//  channel  direction  signals                      transaction
//  cfg      in         cfg_we, cfg_data             write when cfg_we is high
//  in       in         in_valid, in_ready, in_data  gate and qubit indices
//  out      out        out_valid, out_ready, out_data  error, commute flag, signs
//
// For a valid gate the row sweep does one memory read and one write-back per
// row for each of the 2n rows, then the pair sweep reads the n(n-1)/2 stabiliser
// pairs on the two read ports (n of two or more), with control states around them.
// Reset and every num_qubits write start a pass that rewrites every row;
// no transaction is taken during it. A stalled output holds in its
// register while the next gate is taken and processed.
`timescale 1ns / 1ps

module stabilizer_tableau_clifford_top
  import stc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [NQ_W-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_t            out_data
);

  mem_req_t req;
  row_t     rd_a;
  row_t     rd_b;
  logic     res_valid;
  logic     res_take;
  out_t     result;

  stc_tab_mem u_mem (
    .clk  (clk),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  stc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .result    (result),
    .req       (req),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // Move a finished result into the output register when it is free
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= result;
    end
  end

endmodule
